@@ src/rotation_matrix_to_quaternion_defines.svh @@
// assertion macros for the rotation matrix to quaternion block
// used by rotation_matrix_to_quaternion.sv, expects clk and rst_n in scope
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RMQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq check failed");

// implication after a fixed number of cycles
`define RMQ_ASSERT_LAT(lbl, ante, cons, n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## n (cons)) \
    else $error("rmq latency check failed");

`endif

@@ src/rmq_pkg.sv @@
// shared types and fixed widths for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // signed branch argument, wide enough for one plus three diagonal terms
  localparam int ARG_W   = DATA_WIDTH + 3;
  // a positive argument stays below 2^(DATA_WIDTH+1)
  localparam int ARG_U_W = DATA_WIDTH + 1;
  localparam int ROOT_W  = (ARG_U_W + FRAC_BITS + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  // sum or difference of two elements
  localparam int DIFF_W  = DATA_WIDTH + 1;
  localparam int MAG_W   = DATA_WIDTH + 1;
  localparam int NUM_W   = MAG_W + FRAC_BITS;
  localparam int DEN_W   = ROOT_W + 1;
  // divisor 2*s is at least 2^(FRAC_BITS/2+1), so leading quotient bits are zero
  localparam int DIV_SKIP = FRAC_BITS / 2 + 1;
  localparam int QUO_W    = NUM_W - DIV_SKIP;

  localparam logic signed [ARG_W-1:0] ONE_Q = ARG_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    BR_W,
    BR_X,
    BR_Y,
    BR_Z
  } rmq_branch_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m13;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic signed [DATA_WIDTH-1:0] m23;
    logic signed [DATA_WIDTH-1:0] m31;
    logic signed [DATA_WIDTH-1:0] m32;
    logic signed [DATA_WIDTH-1:0] m33;
  } rmq_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic                         degenerate;
  } rmq_out_t;

  // per-item control carried alongside the arithmetic
  typedef struct packed {
    rmq_branch_t           br;
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } rmq_side_t;

endpackage

@@ src/rmq_sqrt_pipe.sv @@
// pipelined integer square root, one root bit per register stage
// depends on rmq_pkg
module rmq_sqrt_pipe (
  input  logic                        clk,
  input  logic [rmq_pkg::RAD_W-1:0]   in_rad,
  output logic [rmq_pkg::ROOT_W-1:0]  out_root
);
  import rmq_pkg::*;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];

  genvar g;
  generate
    for (g = 0; g < ROOT_W; g++) begin : g_stage
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;
      logic [REM_W+1:0]  tmp;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              ge;
      logic [REM_W-1:0]  rem_nxt;
      logic [ROOT_W-1:0] root_nxt;
      logic [RAD_W-1:0]  rad_nxt;

      if (g == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = in_rad;
      end else begin : g_next
        assign rem_in  = rem_r[g-1];
        assign root_in = root_r[g-1];
        assign rad_in  = rad_r[g-1];
      end

      // bring down two radicand bits, try 4*root+1
      assign tmp      = {rem_in, rad_in[RAD_W-1 -: 2]};
      assign trial    = (REM_W+2)'({root_in, 2'b01});
      assign ge       = (tmp >= trial);
      assign diff     = tmp - trial;
      assign rem_nxt  = ge ? diff[REM_W-1:0] : tmp[REM_W-1:0];
      assign root_nxt = {root_in[ROOT_W-2:0], ge};
      assign rad_nxt  = rad_in << 2;

      always_ff @(posedge clk) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= rad_nxt;
      end
    end
  endgenerate

  assign out_root = root_r[ROOT_W-1];

endmodule

@@ src/rmq_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per register stage
// depends on rmq_pkg; divisor must be at least 2^DIV_SKIP
module rmq_div_pipe (
  input  logic                       clk,
  input  logic [rmq_pkg::NUM_W-1:0]  in_num,
  input  logic [rmq_pkg::DEN_W-1:0]  in_den,
  output logic [rmq_pkg::QUO_W-1:0]  out_quo
);
  import rmq_pkg::*;

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] num_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];

  genvar g;
  generate
    for (g = 0; g < QUO_W; g++) begin : g_stage
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] num_in;
      logic [QUO_W-1:0] quo_in;
      logic [DEN_W-1:0] den_in;
      logic [DEN_W:0]   tmp;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_nxt;
      logic [QUO_W-1:0] quo_nxt;
      logic [QUO_W-1:0] num_nxt;

      if (g == 0) begin : g_first
        // top numerator bits are below the divisor, start with them as remainder
        assign rem_in = DEN_W'(in_num[NUM_W-1 -: DIV_SKIP]);
        assign num_in = in_num[QUO_W-1:0];
        assign quo_in = '0;
        assign den_in = in_den;
      end else begin : g_next
        assign rem_in = rem_r[g-1];
        assign num_in = num_r[g-1];
        assign quo_in = quo_r[g-1];
        assign den_in = den_r[g-1];
      end

      // shift in one numerator bit, subtract divisor when it fits
      assign tmp     = {rem_in, num_in[QUO_W-1]};
      assign ge      = (tmp >= {1'b0, den_in});
      assign diff    = tmp - {1'b0, den_in};
      assign rem_nxt = ge ? diff[DEN_W-1:0] : tmp[DEN_W-1:0];
      assign quo_nxt = {quo_in[QUO_W-2:0], ge};
      assign num_nxt = num_in << 1;

      always_ff @(posedge clk) begin
        rem_r[g] <= rem_nxt;
        num_r[g] <= num_nxt;
        quo_r[g] <= quo_nxt;
        den_r[g] <= den_in;
      end
    end
  endgenerate

  assign out_quo = quo_r[QUO_W-1];

endmodule

@@ src/rotation_matrix_to_quaternion.sv @@
// rotation matrix to unit quaternion, branch on trace or largest diagonal
// pipeline from start to out_valid: 1 branch stage, 16 square-root
// stages (one root bit each), 23 divider stages (one quotient bit each), 1 output
// throughput one matrix per cycle, busy is always low; no backpressure on results
// synchronous active-low reset clears the valid bits only; depends on rmq_pkg,
// rmq_sqrt_pipe, rmq_div_pipe
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic              out_valid,
  output rmq_pkg::rmq_out_t out_data
);
  import rmq_pkg::*;

  localparam int LAT = 1 + ROOT_W + QUO_W + 1;

  // saturate a signed magnitude to the output word
  function automatic logic signed [DATA_WIDTH-1:0] sat_q(input logic neg,
                                                         input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] lim;
    logic signed [DATA_WIDTH-1:0] res;
    lim = QUO_W'(1) << (DATA_WIDTH - 1);
    if (neg) begin
      if (q >= lim) res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else          res = -DATA_WIDTH'(q);
    end else begin
      if (q >= lim) res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else          res = DATA_WIDTH'(q);
    end
    return res;
  endfunction

  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // branch select and square-root argument
  logic signed [ARG_W-1:0]  e11, e22, e33, trace, arg;
  logic signed [DIFF_W-1:0] d23m32, d31m13, d12m21, d12p21, d13p31, d23p32;
  logic signed [DIFF_W-1:0] dsel [3];
  rmq_branch_t              br;
  rmq_side_t                side_nxt;
  logic [RAD_W-1:0]         rad_nxt;

  assign e11   = ARG_W'(in_data.m11);
  assign e22   = ARG_W'(in_data.m22);
  assign e33   = ARG_W'(in_data.m33);
  assign trace = e11 + e22 + e33;

  assign d23m32 = DIFF_W'(in_data.m23) - DIFF_W'(in_data.m32);
  assign d31m13 = DIFF_W'(in_data.m31) - DIFF_W'(in_data.m13);
  assign d12m21 = DIFF_W'(in_data.m12) - DIFF_W'(in_data.m21);
  assign d12p21 = DIFF_W'(in_data.m12) + DIFF_W'(in_data.m21);
  assign d13p31 = DIFF_W'(in_data.m13) + DIFF_W'(in_data.m31);
  assign d23p32 = DIFF_W'(in_data.m23) + DIFF_W'(in_data.m32);

  always_comb begin
    if (trace > 0) begin
      br  = BR_W;
      arg = trace + ONE_Q;
    end else if (e11 >= e22 && e11 >= e33) begin
      br  = BR_X;
      arg = ONE_Q + e11 - e22 - e33;
    end else if (e22 > e33) begin
      br  = BR_Y;
      arg = ONE_Q + e22 - e11 - e33;
    end else begin
      br  = BR_Z;
      arg = ONE_Q + e33 - e11 - e22;
    end

    // three off-diagonal terms in slot order, own component handled apart
    unique case (br)
      BR_W: begin
        dsel[0] = d23m32; dsel[1] = d31m13; dsel[2] = d12m21;
      end
      BR_X: begin
        dsel[0] = d12p21; dsel[1] = d13p31; dsel[2] = d23m32;
      end
      BR_Y: begin
        dsel[0] = d12p21; dsel[1] = d23p32; dsel[2] = d31m13;
      end
      default: begin
        dsel[0] = d13p31; dsel[1] = d23p32; dsel[2] = d12m21;
      end
    endcase

    side_nxt.br    = br;
    side_nxt.degen = arg[ARG_W-1] || (arg == '0);
    for (int k = 0; k < 3; k++) begin
      side_nxt.neg[k] = dsel[k][DIFF_W-1];
      side_nxt.mag[k] = dsel[k][DIFF_W-1] ? MAG_W'(-dsel[k]) : MAG_W'(dsel[k]);
    end
    rad_nxt = side_nxt.degen ? '0
                             : RAD_W'({arg[ARG_U_W-1:0], {FRAC_BITS{1'b0}}});
  end

  logic             valid1_r;
  rmq_side_t        side1_r;
  logic [RAD_W-1:0] rad1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid1_r <= 1'b0;
    else        valid1_r <= in_fire;
    side1_r <= side_nxt;
    rad1_r  <= rad_nxt;
  end

  // square root stages, control word delayed alongside
  logic [ROOT_W-1:0] root;
  logic              sq_valid_r [ROOT_W];
  rmq_side_t         sq_side_r  [ROOT_W];

  rmq_sqrt_pipe u_sqrt (
    .clk      (clk),
    .in_rad   (rad1_r),
    .out_root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_W; i++) sq_valid_r[i] <= 1'b0;
    end else begin
      sq_valid_r[0] <= valid1_r;
      for (int i = 1; i < ROOT_W; i++) sq_valid_r[i] <= sq_valid_r[i-1];
    end
    sq_side_r[0] <= side1_r;
    for (int i = 1; i < ROOT_W; i++) sq_side_r[i] <= sq_side_r[i-1];
  end

  // three dividers: (|d| * 2^F + s) / (2 s)
  logic [DEN_W-1:0]  den;
  logic [QUO_W-1:0]  quo [3];
  logic              dv_valid_r [QUO_W];
  rmq_side_t         dv_side_r  [QUO_W];
  logic [ROOT_W-1:0] dv_root_r  [QUO_W];

  assign den = {root, 1'b0};

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_div
      logic [NUM_W-1:0] num;
      assign num = NUM_W'({sq_side_r[ROOT_W-1].mag[k], {FRAC_BITS{1'b0}}})
                 + NUM_W'(root);
      rmq_div_pipe u_div (
        .clk     (clk),
        .in_num  (num),
        .in_den  (den),
        .out_quo (quo[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) dv_valid_r[i] <= 1'b0;
    end else begin
      dv_valid_r[0] <= sq_valid_r[ROOT_W-1];
      for (int i = 1; i < QUO_W; i++) dv_valid_r[i] <= dv_valid_r[i-1];
    end
    dv_side_r[0] <= sq_side_r[ROOT_W-1];
    dv_root_r[0] <= root;
    for (int i = 1; i < QUO_W; i++) begin
      dv_side_r[i] <= dv_side_r[i-1];
      dv_root_r[i] <= dv_root_r[i-1];
    end
  end

  // place components by branch, saturate, zero on degenerate
  rmq_side_t                    fin_side;
  logic [ROOT_W:0]              own_sum;
  logic signed [DATA_WIDTH-1:0] own_q, q0, q1, q2;
  rmq_out_t                     out_nxt;
  rmq_out_t                     out_data_r;
  logic                         out_valid_r;

  assign fin_side = dv_side_r[QUO_W-1];
  assign own_sum  = (ROOT_W+1)'(dv_root_r[QUO_W-1]) + (ROOT_W+1)'(1);

  always_comb begin
    own_q = sat_q(1'b0, QUO_W'(own_sum[ROOT_W:1]));
    q0    = sat_q(fin_side.neg[0], quo[0]);
    q1    = sat_q(fin_side.neg[1], quo[1]);
    q2    = sat_q(fin_side.neg[2], quo[2]);
    unique case (fin_side.br)
      BR_W: begin
        out_nxt.quat_w = own_q; out_nxt.quat_x = q0;
        out_nxt.quat_y = q1;    out_nxt.quat_z = q2;
      end
      BR_X: begin
        out_nxt.quat_x = own_q; out_nxt.quat_y = q0;
        out_nxt.quat_z = q1;    out_nxt.quat_w = q2;
      end
      BR_Y: begin
        out_nxt.quat_y = own_q; out_nxt.quat_x = q0;
        out_nxt.quat_z = q1;    out_nxt.quat_w = q2;
      end
      default: begin
        out_nxt.quat_z = own_q; out_nxt.quat_x = q0;
        out_nxt.quat_y = q1;    out_nxt.quat_w = q2;
      end
    endcase
    out_nxt.degenerate = fin_side.degen;
    if (fin_side.degen) begin
      out_nxt.quat_w = '0;
      out_nxt.quat_x = '0;
      out_nxt.quat_y = '0;
      out_nxt.quat_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_valid_r[QUO_W-1];
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `RMQ_ASSERT_IMP(a_trace_not_degen, valid1_r && side1_r.br == BR_W, !side1_r.degen)
  `RMQ_ASSERT_IMP(a_degen_zero, out_valid_r && out_data_r.degenerate,
    out_data_r.quat_w == '0 && out_data_r.quat_x == '0 &&
    out_data_r.quat_y == '0 && out_data_r.quat_z == '0)
  `RMQ_ASSERT_LAT(a_latency, in_fire, out_valid, LAT)

endmodule
